/* hw/rtl/amb_pkg.sv */
// Shared types and constants for the affine matrix builder.
`default_nettype none
package amb_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int ANGLE_BITS_DEF = 16;

    // Q30 Taylor coefficients of sin(pi/2 * x)
    localparam logic signed [33:0] C_A1 = 34'sd1686629713;
    localparam logic signed [33:0] C_A3 = 34'sd693598669;
    localparam logic signed [33:0] C_A5 = 34'sd85569306;
    localparam logic signed [33:0] C_A7 = 34'sd5026995;
    localparam logic signed [33:0] C_A9 = 34'sd172272;
    localparam logic [30:0]        Q30_ONE = 31'h4000_0000;

    typedef struct packed {
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
        logic        [15:0] angle_x;
        logic        [15:0] angle_y;
        logic        [15:0] angle_z;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
    } item_t;

    typedef struct packed {
        logic        [1:0]  row_index;
        logic signed [31:0] entry_0;
        logic signed [31:0] entry_1;
        logic signed [31:0] entry_2;
        logic signed [31:0] entry_3;
        logic               last_row;
    } row_t;

endpackage
`default_nettype wire

/* hw/rtl/affine_matrix_builder.sv */
// Top level: scale-rotate-translate 4x4 affine matrix builder.
`default_nettype none
// A beat is accepted on start while busy is low. busy rises after each
// accept and holds off the next item until the single result port, which
// carries the four rows of a matrix one per cycle, has room for its rows;
// items still overlap in the pipeline. Rows leave in order 0..3 with valid
// high for exactly one cycle each; last_row marks row 3. The receiver cannot
// stall, so every row must be taken the cycle it appears. From accept to row
// 0 the beat passes the sine/cosine units, then the Ry*Rz product, the Rx
// product, the scale multiply, and the output register. Rows of back-to-back
// items follow each other with no gap. No state, no config.
module affine_matrix_builder
    import amb_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire item_t item,
    output logic       valid,
    output row_t       result
);

    localparam int SW = FRAC_BITS + 2;   // sine width
    localparam int MW = SW + 1;          // combined rotation entry width
    localparam logic signed [SW-1:0] ONE = SW'(1) <<< FRAC_BITS;

    function automatic logic signed [MW-1:0] qm(input logic signed [SW-1:0] a,
                                                 input logic signed [SW-1:0] b);
        logic signed [2*SW-1:0] p;
        p = (2*SW)'(a) * (2*SW)'(b);
        return MW'(p >>> FRAC_BITS);
    endfunction

    logic       accept;
    logic [1:0] busy_reg;
    logic [8:0] v_reg;
    item_t      d_reg [0:8];

    assign accept = start && (busy_reg == 2'd0);
    assign busy   = (busy_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 2'd0;
            v_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 2'd3;
            end
            else if (busy_reg != 2'd0)
            begin
                busy_reg <= busy_reg - 2'd1;
            end
            v_reg <= {v_reg[7:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg[0] <= item;
        for (int k = 1; k <= 8; k++)
        begin
            d_reg[k] <= d_reg[k-1];
        end
    end

    // sine / cosine lanes, six stages
    logic signed [SW-1:0] sx, cx, sy, cy, sz, cz;

    amb_sin #(.FRAC_BITS(FRAC_BITS), .ANGLE_BITS(ANGLE_BITS)) u_sx
        (.clk(clk), .angle(item.angle_x), .quarter(1'b0), .sin_out(sx));
    amb_sin #(.FRAC_BITS(FRAC_BITS), .ANGLE_BITS(ANGLE_BITS)) u_cx
        (.clk(clk), .angle(item.angle_x), .quarter(1'b1), .sin_out(cx));
    amb_sin #(.FRAC_BITS(FRAC_BITS), .ANGLE_BITS(ANGLE_BITS)) u_sy
        (.clk(clk), .angle(item.angle_y), .quarter(1'b0), .sin_out(sy));
    amb_sin #(.FRAC_BITS(FRAC_BITS), .ANGLE_BITS(ANGLE_BITS)) u_cy
        (.clk(clk), .angle(item.angle_y), .quarter(1'b1), .sin_out(cy));
    amb_sin #(.FRAC_BITS(FRAC_BITS), .ANGLE_BITS(ANGLE_BITS)) u_sz
        (.clk(clk), .angle(item.angle_z), .quarter(1'b0), .sin_out(sz));
    amb_sin #(.FRAC_BITS(FRAC_BITS), .ANGLE_BITS(ANGLE_BITS)) u_cz
        (.clk(clk), .angle(item.angle_z), .quarter(1'b1), .sin_out(cz));

    // Ry*Rz; zero and unit terms drop out exactly. Kept with the x terms.
    logic signed [SW-1:0] yz_reg [0:2][0:2];
    logic signed [SW-1:0] sx_reg, cx_reg;

    always_ff @(posedge clk)
    begin
        yz_reg[0][0] <= SW'(qm(cy, cz));
        yz_reg[0][1] <= SW'(qm(cy, sz));
        yz_reg[0][2] <= -sy;
        yz_reg[1][0] <= -sz;
        yz_reg[1][1] <= cz;
        yz_reg[1][2] <= '0;
        yz_reg[2][0] <= SW'(qm(sy, cz));
        yz_reg[2][1] <= SW'(qm(sy, sz));
        yz_reg[2][2] <= cy;
        sx_reg       <= sx;
        cx_reg       <= cx;
    end

    // M = Rx*(Ry*Rz); floor is applied to each product, so -sx is negated first
    logic signed [MW-1:0] m_reg [0:2][0:2];

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            m_reg[0][j] <= MW'(yz_reg[0][j]);
            m_reg[1][j] <= qm(cx_reg, yz_reg[1][j]) + qm(sx_reg, yz_reg[2][j]);
            m_reg[2][j] <= qm(-sx_reg, yz_reg[1][j]) + qm(cx_reg, yz_reg[2][j]);
        end
    end

    // row scale
    logic signed [31:0] r_reg [0:2][0:2];
    logic signed [31:0] scl   [0:2];

    assign scl[0] = d_reg[7].scale_x;
    assign scl[1] = d_reg[7].scale_y;
    assign scl[2] = d_reg[7].scale_z;

    always_ff @(posedge clk)
    begin
        logic signed [63:0] p;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                p = 64'(m_reg[i][j]) * 64'(scl[i]);
                r_reg[i][j] <= 32'(p >>> FRAC_BITS);
            end
        end
    end

    // output serializer: one row per cycle
    logic signed [31:0] h_reg [0:3][0:3];
    logic [1:0]         cnt_reg;
    logic               act_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            act_reg <= 1'b0;
        end
        else
        begin
            if (v_reg[8])
            begin
                cnt_reg <= 2'd0;
                act_reg <= 1'b1;
            end
            else if (act_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    act_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (v_reg[8])
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    h_reg[i][j] <= r_reg[i][j];
                end
                h_reg[i][3] <= '0;
            end
            h_reg[3][0] <= d_reg[8].offset_x;
            h_reg[3][1] <= d_reg[8].offset_y;
            h_reg[3][2] <= d_reg[8].offset_z;
            h_reg[3][3] <= 32'(ONE);
        end
    end

    assign valid            = act_reg;
    assign result.row_index = cnt_reg;
    assign result.entry_0   = h_reg[cnt_reg][0];
    assign result.entry_1   = h_reg[cnt_reg][1];
    assign result.entry_2   = h_reg[cnt_reg][2];
    assign result.entry_3   = h_reg[cnt_reg][3];
    assign result.last_row  = (cnt_reg == 2'd3);

endmodule
`default_nettype wire

/* hw/rtl/amb_sin.sv */
// Six-stage pipelined fixed-point sine of a binary angle.
`default_nettype none
module amb_sin
    import amb_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic [15:0]                angle,
    input  wire logic                       quarter,   // 1: cosine
    output logic signed [FRAC_BITS+1:0]     sin_out
);

    localparam int SW = FRAC_BITS + 2;
    localparam logic signed [SW-1:0] ONE = SW'(1) <<< FRAC_BITS;

    logic [31:0] phase;
    logic [30:0] x_in;
    logic [63:0] sq;

    logic [30:0]        x_reg   [0:4];
    logic [1:0]         quad_reg[0:4];
    logic [30:0]        x2_reg  [0:3];
    logic signed [33:0] p_reg   [1:4];
    logic signed [SW-1:0] s_reg;

    logic signed [33:0] coef [1:4];
    logic signed [33:0] p_next [1:4];
    logic signed [63:0] fin_prod;
    logic signed [63:0] fin_shift;
    logic signed [SW-1:0] s_next;

    assign coef[1] = -C_A7;
    assign coef[2] =  C_A5;
    assign coef[3] = -C_A3;
    assign coef[4] =  C_A1;

    always_comb
    begin
        phase = (32'(angle) << (32 - ANGLE_BITS)) + {quarter, 31'b0} - {quarter, 30'b0};
        x_in  = {1'b0, phase[29:0]};
        if (phase[30])
        begin
            x_in = Q30_ONE - x_in;
        end
        sq = 64'(x_in) * 64'(x_in);
    end

    // Horner steps; stage 1 starts from the x^9 coefficient.
    // x^2 travels with the beat, one copy per step.
    always_comb
    begin
        logic signed [63:0] prod;
        for (int k = 1; k <= 4; k++)
        begin
            if (k == 1)
            begin
                prod = 64'(C_A9) * $signed({33'b0, x2_reg[k-1]});
            end
            else
            begin
                prod = 64'(p_reg[k-1]) * $signed({33'b0, x2_reg[k-1]});
            end
            p_next[k] = 34'(prod >>> 30) + coef[k];
        end
    end

    always_comb
    begin
        fin_prod  = 64'(p_reg[4]) * $signed({33'b0, x_reg[4]});
        fin_shift = fin_prod >>> (60 - FRAC_BITS);
        if (fin_shift < 0)
        begin
            s_next = '0;
        end
        else if (fin_shift > 64'(ONE))
        begin
            s_next = ONE;
        end
        else
        begin
            s_next = SW'(fin_shift);
        end
        if (quad_reg[4][1])
        begin
            s_next = -s_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= x_in;
        quad_reg[0] <= phase[31:30];
        x2_reg[0]   <= sq[60:30];
        for (int k = 1; k <= 3; k++)
        begin
            x2_reg[k] <= x2_reg[k-1];
        end
        for (int k = 1; k <= 4; k++)
        begin
            x_reg[k]    <= x_reg[k-1];
            quad_reg[k] <= quad_reg[k-1];
            p_reg[k]    <= p_next[k];
        end
        s_reg <= s_next;
    end

    assign sin_out = s_reg;

endmodule
`default_nettype wire

/* bench/affine_matrix_builder_test.sv */
// Testbench for affine_matrix_builder: directed and random items, rows checked by a scoreboard.
`timescale 1ns / 1ps

import amb_pkg::*;

// Predicts the four rows of each matrix and checks them in order.
class row_scoreboard;
    row_t   pending_rows[$];
    int     mismatches;
    int     rows_seen;
    int     items_seen;

    // Sine of a 32-bit phase, Q16.16, by the same truncating polynomial as the hardware
    function longint q16_sine(bit [31:0] phase);
        longint x;
        longint x2;
        longint p;
        longint s;
        x = longint'(phase[29:0]);
        if (phase[30])
            x = longint'(Q30_ONE) - x;
        x2 = (x * x) >>> 30;
        p = longint'(C_A9);
        p = ((p * x2) >>> 30) - longint'(C_A7);
        p = ((p * x2) >>> 30) + longint'(C_A5);
        p = ((p * x2) >>> 30) - longint'(C_A3);
        p = ((p * x2) >>> 30) + longint'(C_A1);
        s = (p * x) >>> 30;
        s = s >>> 14;
        if (s < 0)
            s = 0;
        if (s > 65536)
            s = 65536;
        return phase[31] ? -s : s;
    endfunction

    function longint fx_mul(longint a, longint b);
        return (a * b) >>> 16;
    endfunction

    function void note_item(item_t it);
        longint sa[3];
        longint ca[3];
        longint rx[3][3];
        longint ry[3][3];
        longint rz[3][3];
        longint yz[3][3];
        longint m[3][3];
        longint scl[3];
        longint acc;
        bit [31:0] ph;
        row_t r;
        bit [15:0] ang[3];
        ang[0] = it.angle_x;
        ang[1] = it.angle_y;
        ang[2] = it.angle_z;
        for (int a = 0; a < 3; a++)
        begin
            ph = {ang[a], 16'h0000};
            sa[a] = q16_sine(ph);
            ca[a] = q16_sine(ph + 32'h4000_0000);
        end
        scl[0] = it.scale_x;
        scl[1] = it.scale_y;
        scl[2] = it.scale_z;
        rx = '{'{65536, 0, 0}, '{0, ca[0], sa[0]}, '{0, -sa[0], ca[0]}};
        ry = '{'{ca[1], 0, -sa[1]}, '{0, 65536, 0}, '{sa[1], 0, ca[1]}};
        rz = '{'{ca[2], sa[2], 0}, '{-sa[2], ca[2], 0}, '{0, 0, 65536}};
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += fx_mul(ry[i][k], rz[k][j]);
                yz[i][j] = acc;
            end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += fx_mul(rx[i][k], yz[k][j]);
                m[i][j] = acc;
            end
        // rows 0..2 scaled per axis; entries wrap to 32 bits
        for (int i = 0; i < 3; i++)
        begin
            r.row_index = 2'(i);
            r.entry_0   = 32'(fx_mul(m[i][0], scl[i]));
            r.entry_1   = 32'(fx_mul(m[i][1], scl[i]));
            r.entry_2   = 32'(fx_mul(m[i][2], scl[i]));
            r.entry_3   = '0;
            r.last_row  = 1'b0;
            pending_rows.push_back(r);
        end
        r.row_index = 2'd3;
        r.entry_0   = it.offset_x;
        r.entry_1   = it.offset_y;
        r.entry_2   = it.offset_z;
        r.entry_3   = 32'h0001_0000;
        r.last_row  = 1'b1;
        pending_rows.push_back(r);
        items_seen++;
    endfunction

    function void check_row(row_t got);
        row_t want;
        rows_seen++;
        if (pending_rows.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("row with nothing expected: %p", got);
            return;
        end
        want = pending_rows.pop_front();
        if (got.row_index !== want.row_index || got.entry_0 !== want.entry_0 ||
            got.entry_1 !== want.entry_1 || got.entry_2 !== want.entry_2 ||
            got.entry_3 !== want.entry_3 || got.last_row !== want.last_row)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("row mismatch: expected %p, got %p", want, got);
        end
    endfunction
endclass

module affine_matrix_builder_test;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    item_t item = '0;
    logic  busy;
    logic  valid;
    row_t  result;

    row_scoreboard board = new();

    always #5 clk = ~clk;

    affine_matrix_builder DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .valid  (valid),
        .result (result)
    );

    // Rows cannot be held off: take each one on the edge that ends its strobe cycle.
    always @(posedge clk)
        if (rst_n && valid)
            board.check_row(result);

    // Drive one beat; start stays high on return so a zero gap needs no toggle.
    task automatic send_beat(item_t it);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        // accepted at the first edge where busy was low
        do
            @(posedge clk);
        while (busy);
        board.note_item(it);
    endtask

    function automatic item_t random_item(bit wide);
        item_t it;
        logic [255:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[239:0];
        if (!wide)
        begin
            // modest scales keep entries in range most of the time
            it.scale_x = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            it.scale_y = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            it.scale_z = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        end
        return it;
    endfunction

    function automatic item_t make_item(int sx, int sy, int sz,
                                        bit [15:0] ax, bit [15:0] ay, bit [15:0] az,
                                        int ox, int oy, int oz);
        item_t it;
        it.scale_x = sx; it.scale_y = sy; it.scale_z = sz;
        it.angle_x = ax; it.angle_y = ay; it.angle_z = az;
        it.offset_x = ox; it.offset_y = oy; it.offset_z = oz;
        return it;
    endfunction

    localparam int ONE    = 32'h0001_0000;
    localparam int MOST   = 32'h7FFF_FFFF;
    localparam int LEAST  = 32'h8000_0000;

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity, quadrant boundaries, extremes, wraparound
        send_beat(make_item(ONE, ONE, ONE, 0, 0, 0, 0, 0, 0));
        send_beat(make_item(ONE, ONE, ONE, 16'h4000, 0, 0, 1, 2, 3));
        send_beat(make_item(ONE, ONE, ONE, 0, 16'h4000, 0, -1, -2, -3));
        send_beat(make_item(ONE, ONE, ONE, 0, 0, 16'h4000, MOST, LEAST, 0));
        send_beat(make_item(ONE, ONE, ONE, 16'h8000, 16'h8000, 16'h8000, LEAST, MOST, -1));
        send_beat(make_item(ONE, ONE, ONE, 16'hC000, 16'hC000, 16'hC000, 0, 0, 0));
        send_beat(make_item(ONE, ONE, ONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0));
        send_beat(make_item(ONE, ONE, ONE, 16'h0001, 16'h7FFF, 16'h8001, 0, 0, 0));
        send_beat(make_item(MOST, MOST, MOST, 16'h2000, 16'h6000, 16'hA000, 0, 0, 0));
        send_beat(make_item(LEAST, LEAST, LEAST, 0, 0, 0, 0, 0, 0));
        // -1.0 times -32768.0 wraps
        send_beat(make_item(LEAST, LEAST, LEAST, 0, 0, 16'h8000, 0, 0, 0));
        send_beat(make_item(LEAST, MOST, 0, 16'h8000, 16'h8000, 0, 0, 0, 0));
        send_beat(make_item(-1, 1, 0, 16'h1234, 16'h5678, 16'h9ABC, 0, 0, 0));
        send_beat(make_item(-ONE, -ONE, -ONE, 16'hE000, 16'h1000, 16'h3000, ONE, -ONE, 0));

        for (int n = 0; n < 96; n++)
            send_beat(random_item($urandom_range(0, 3) == 0));
        start <= 1'b0;

        while (board.pending_rows.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d matrices (quadrant edges, full-range scales and offsets, wrapped",
                 board.items_seen);
        $display("entries), checked %0d rows, %0d mismatches.", board.rows_seen,
                 board.mismatches);
        if (board.mismatches == 0)
            $display("PASS affine_matrix_builder");
        else
            $display("FAIL affine_matrix_builder");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("timeout");
        $display("FAIL affine_matrix_builder");
        $finish;
    end

endmodule
